// File: sv/plel_pkg.sv
// Package for the positional list engine.
// Holds the command codes and the field widths shared by the top level and the entry memory.
// No dependencies.
package plel_pkg;

	localparam int CMD_W   = 2;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// File: sv/plel_mem.sv
// Entry memory of the positional list engine: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address. Uses plel_pkg.
module plel_mem
	import plel_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  value_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output value_t        rd_data
);

	value_t mem [DEPTH];
	value_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/positional_list_engine.sv
// Positional list engine: an ordered list of signed 32-bit entries, addressed by 1-based
// position, held in a single-port-write, single-port-read memory. One command is handled at
// a time. An insert or a delete moves every later entry one slot through the memory, one
// move per cycle, so the longest command is an insert at position 1. Rejected commands
// move no entries. No clearing pass is needed after reset.
// Depends on plel_pkg and plel_mem.
module positional_list_engine
	import plel_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[1:0], position[8:2], value[40:9], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[0], read_value[32:1], count[39:33]
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_RDW  = 3'd2;
	localparam logic [2:0] ST_MOVE = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    src_q;
	logic [CW-1:0]    left_q;
	logic             ins_q;
	logic [AW-1:0]    slot_q;
	value_t           value_q;
	logic             pend_s1;
	logic [AW-1:0]    dst_s1;
	logic             res_status_q;
	value_t           res_value_q;
	logic             m_tvalid_q;
	logic [39:0]      m_tdata_q;

	logic [CMD_W-1:0] in_cmd;
	logic [POS_W-1:0] in_pos;
	value_t           in_value;
	logic [XW-1:0]    pos_x;
	logic [XW-1:0]    cnt_x;
	logic             pos_nz;
	logic             ok_rd;
	logic             ok_ins;
	logic             ok_del;
	logic             accept;

	logic             mem_wr_en;
	logic [AW-1:0]    mem_wr_addr;
	value_t           mem_wr_data;
	logic [AW-1:0]    mem_rd_addr;
	value_t           mem_rd_data;

	assign in_cmd   = s_tdata[1:0];
	assign in_pos   = s_tdata[8:2];
	assign in_value = s_tdata[40:9];

	assign pos_x  = XW'(in_pos);
	assign cnt_x  = XW'(count_q);
	assign pos_nz = (in_pos != '0);
	assign ok_rd  = pos_nz && (pos_x <= cnt_x);
	assign ok_del = ok_rd;
	assign ok_ins = pos_nz && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// The move pipeline writes the entry read in the previous cycle; the read and write
	// addresses in one cycle are always two slots apart, so no forwarding is needed.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = dst_s1;
		mem_wr_data = mem_rd_data;
		mem_rd_addr = slot_q;
		case (state_q)
			ST_MOVE: begin
				mem_wr_en   = pend_s1;
				mem_rd_addr = src_q[AW-1:0];
			end
			ST_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q;
				mem_wr_data = value_q;
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	plel_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// In ST_RESP the valid flag is handled by the state arm below.
			if (m_tvalid_q && m_tready && (state_q != ST_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_s1 <= 1'b0;
						case (in_cmd)
							CMD_READ: begin
								state_q <= ok_rd ? ST_RD : ST_RESP;
							end
							CMD_INSERT: begin
								if (ok_ins) begin
									count_q <= count_q + CW'(1);
									state_q <= ST_MOVE;
								end else begin
									state_q <= ST_RESP;
								end
							end
							CMD_DELETE: begin
								if (ok_del) begin
									count_q <= count_q - CW'(1);
									state_q <= ST_MOVE;
								end else begin
									state_q <= ST_RESP;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					state_q <= ST_RESP;
				end
				ST_MOVE: begin
					if (left_q != '0) begin
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= ins_q ? ST_PUT : ST_RESP;
						end
					end
				end
				ST_PUT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ins_q       <= (in_cmd == CMD_INSERT);
					slot_q      <= AW'(in_pos - POS_W'(1));
					value_q     <= in_value;
					res_value_q <= '0;
					if (in_cmd == CMD_INSERT) begin
						// Entries count-1 down to pos-1 move up one slot.
						src_q        <= count_q - CW'(1);
						left_q       <= CW'(cnt_x - pos_x + XW'(1));
						res_status_q <= ok_ins ? STATUS_DONE : STATUS_REJECTED;
					end else begin
						// Entries pos up to count-1 move down one slot.
						src_q        <= CW'(pos_x);
						left_q       <= CW'(cnt_x - pos_x);
						res_status_q <= ((in_cmd == CMD_READ) || (in_cmd == CMD_DELETE))
							&& ok_rd ? STATUS_DONE : STATUS_REJECTED;
					end
				end
			end
			ST_RDW: begin
				res_value_q <= mem_rd_data;
			end
			ST_MOVE: begin
				if (left_q != '0) begin
					left_q <= left_q - CW'(1);
					if (ins_q) begin
						dst_s1 <= AW'(src_q + CW'(1));
						src_q  <= src_q - CW'(1);
					end else begin
						dst_s1 <= AW'(src_q - CW'(1));
						src_q  <= src_q + CW'(1);
					end
				end
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {COUNT_W'(count_q), res_value_q, res_status_q};
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: test/positional_list_engine_test.sv
// Self-checking testbench for positional_list_engine.
// Drives read, insert and delete commands on the stream input and checks every result
// against a behavioral list kept in the testbench. Depends on plel_pkg and the engine RTL.
module positional_list_engine_test;
	import plel_pkg::*;

	localparam int LIST_CAP    = 64;
	localparam int CLK_HALF    = 6;
	localparam int TAIL_CYCLES = 80;
	localparam int WAIT_LIMIT  = 20000;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic                 status;
		value_t               read_value;
		logic [COUNT_W-1:0]   count;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // command[1:0], position[8:2], value[40:9], zero fill
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // status[0], read_value[32:1], count[39:33]

	// Behavioral copy of the list.
	value_t list_mem [LIST_CAP];
	int     list_len;

	list_result_t pending_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int error_count;
	int n_reads, n_inserts, n_deletes, n_rejected, n_results;
	bit reached_full;

	positional_list_engine #(.CAPACITY(LIST_CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	initial begin
		#(CLK_HALF * 2 * 2000000);
		$display("positional_list_engine_test NOT OK");
		$finish;
	end

	// Applies one command to the list and returns the result the engine should give.
	function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input value_t val);
		list_result_t res;
		int k;
		res.status     = STATUS_REJECTED;
		res.read_value = '0;
		case (cmd)
			CMD_READ: begin
				if (pos >= 1 && pos <= list_len) begin
					res.read_value = list_mem[pos - 1];
					res.status     = STATUS_DONE;
				end
			end
			CMD_INSERT: begin
				if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_CAP) begin
					for (k = list_len; k > pos - 1; k--)
						list_mem[k] = list_mem[k - 1];
					list_mem[pos - 1] = val;
					list_len++;
					res.status = STATUS_DONE;
				end
			end
			CMD_DELETE: begin
				if (pos >= 1 && pos <= list_len) begin
					for (k = pos - 1; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k + 1];
					list_len--;
					res.status = STATUS_DONE;
				end
			end
			default: ;
		endcase
		res.count = COUNT_W'(list_len);
		return res;
	endfunction

	// Offers one command and records the expected result once the transaction is taken.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input value_t val);
		list_result_t res;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, val, pos, cmd};
		do @(posedge clk); while (!s_tready);
		res = apply_command(cmd, pos, val);
		pending_results.push_back(res);
		if (res.status == STATUS_REJECTED)
			n_rejected++;
		else if (cmd == CMD_READ)
			n_reads++;
		else if (cmd == CMD_INSERT)
			n_inserts++;
		else
			n_deletes++;
		if (list_len == LIST_CAP)
			reached_full = 1'b1;
	endtask

	// Stops offering and waits for every outstanding result.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_present_pos();
		return (list_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, list_len));
	endfunction

	task automatic check_result(input logic [39:0] data);
		list_result_t want;
		n_results++;
		if (pending_results.size() == 0) begin
			$error("result with nothing expected: tdata %h", data);
			error_count++;
		end else begin
			want = pending_results.pop_front();
			if (data[0] !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, data[0]);
				error_count++;
			end
			if (data[32:1] !== want.read_value) begin
				$error("read_value: expected %0d, got %0d", want.read_value,
					$signed(data[32:1]));
				error_count++;
			end
			if (data[39:33] !== want.count) begin
				$error("count: expected %0d, got %0d", want.count, data[39:33]);
				error_count++;
			end
		end
	endtask

	// Result side: checks each transaction and stalls at random, or for a long
	// stretch when stall_left is loaded.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result(m_tdata);
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic test_directed_corners();
		send_command(CMD_READ, 1, 0);
		send_command(CMD_READ, 0, 0);
		send_command(CMD_DELETE, 1, 0);
		send_command(CMD_INSERT, 0, 5);
		send_command(CMD_INSERT, 2, 5);
		send_command(CMD_INSERT, 1, 32'sh7fffffff);
		send_command(CMD_INSERT, 1, 32'sh80000000);
		send_command(CMD_INSERT, 3, -32'sd1);
		send_command(CMD_INSERT, 2, 0);
		send_command(CMD_INSERT, 127, 7);
		// The unused command code is rejected like a bad position.
		send_command(CMD_UNUSED, 127, -32'sd1);
		send_command(CMD_READ, 1, 0);
		send_command(CMD_READ, 4, 0);
		send_command(CMD_READ, 5, 0);
		send_command(CMD_READ, 127, 0);
		send_command(CMD_DELETE, 5, 0);
		send_command(CMD_DELETE, 2, 0);
		send_command(CMD_DELETE, 3, 0);
		send_command(CMD_READ, 2, 0);
		send_command(CMD_DELETE, 1, 0);
		send_command(CMD_DELETE, 1, 0);
		send_command(CMD_READ, 1, 0);
		send_command(CMD_DELETE, 0, 0);
		send_command(CMD_INSERT, 1, 32'sh55555555);
	endtask

	task automatic test_full_list();
		while (list_len < LIST_CAP)
			send_command(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value());
		send_command(CMD_INSERT, POS_W'(LIST_CAP + 1), 1);
		send_command(CMD_INSERT, 1, 1);
		send_command(CMD_READ, POS_W'(LIST_CAP), 0);
		send_command(CMD_READ, POS_W'(LIST_CAP + 1), 0);
		send_command(CMD_DELETE, POS_W'(LIST_CAP + 1), 0);
		send_command(CMD_DELETE, POS_W'(LIST_CAP), 0);
		// Longest shifts: every entry moves up, then every later entry moves down.
		send_command(CMD_INSERT, 1, pick_value());
		send_command(CMD_DELETE, 1, 0);
	endtask

	task automatic test_long_stall();
		wait_results_drained();
		stall_left <= 300;
		repeat (20)
			send_command(CMD_INSERT, pick_present_pos(), pick_value());
		wait_results_drained();
	endtask

	// Random traffic that swings the list between empty and full.
	task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
		int i;
		int r;
		bit grow;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (i = 0; i < items; i++) begin
			grow = ((i / 120) % 2) == 0;
			r = $urandom_range(99);
			if (r < 5)
				send_command(CMD_W'($urandom_range(3)), POS_W'($urandom_range(127)),
					pick_value());
			else if (r < 35)
				send_command(CMD_READ, pick_present_pos(), pick_value());
			else if (r < (grow ? 85 : 45))
				send_command(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)),
					pick_value());
			else
				send_command(CMD_DELETE, pick_present_pos(), pick_value());
		end
		wait_results_drained();
	endtask

	initial begin
		int waited;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		stall_left    = 0;
		list_len      = 0;
		error_count   = 0;
		n_reads       = 0;
		n_inserts     = 0;
		n_deletes     = 0;
		n_rejected    = 0;
		n_results     = 0;
		reached_full  = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 53;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_full_list();
		test_long_stall();
		test_random_traffic(360, 12, 53);
		test_random_traffic(360, 53, 12);
		test_random_traffic(360, 0, 0);

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end

		$display("Checked %0d results: %0d reads, %0d inserts, %0d deletes, %0d rejected.",
			n_results, n_reads, n_inserts, n_deletes, n_rejected);
		$display("List filled to capacity: %0s; long output stall and input drain exercised.",
			reached_full ? "yes" : "no");
		if (error_count == 0)
			$display("positional_list_engine_test OK");
		else
			$display("positional_list_engine_test NOT OK");
		$finish;
	end

endmodule
